// ----- rtl/tsq_pkg.sv -----
// shared types and constants for the thick segment quad expander
package tsq_pkg;

  typedef logic signed [31:0] coord_t;
  typedef logic signed [33:0] wide_coord_t;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic [30:0]        radius;
    logic [31:0]        color_rgba;
  } tsq_in_t;

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
    logic [31:0]        vertex_color;
    logic               vertex_last;
  } tsq_out_t;

  // classified segment waiting for the back end
  typedef struct packed {
    logic [2:0][31:0] pos_s;
    logic [2:0][31:0] pos_e;
    logic [2:0][31:0] ab_mag;
    logic [2:0]       ab_neg;
    logic [2:0][33:0] w2;
    logic [30:0]      hw;
    logic [31:0]      color;
    logic             degen;
  } tsq_job_t;

  // quad corners handed to the vertex emitter
  typedef struct packed {
    logic [2:0][33:0] va;
    logic [2:0][33:0] vb;
    logic [2:0][31:0] side;
    logic [31:0]      color;
  } tsq_set_t;

  localparam logic [62:0] SideEps = 63'd35184372;
  localparam int unsigned NumVerts = 6;

endpackage

// ----- rtl/thick_segment_quad_expand.sv -----
// top level of the thick segment quad expander
// Expands a 3D segment into a camera-facing quad of six vertices in Q16.16.
// Segments are accepted in consecutive cycles while the input queue
// (QueueDepth entries) has room. The back end handles one segment at a time
// with a shared multiplier and bit-serial root and divide steps: two square
// roots (33 and 63 steps) and six divides (29 and 31 steps each) for a segment
// that yields a quad; a zero-length segment is dropped from idle and an edge-on
// segment after the second root. The six vertices then leave one per cycle,
// unless the output stalls, from the emitter while the back end starts the next
// segment. Degenerate segments produce no vertices.
module thick_segment_quad_expand import tsq_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  tsq_in_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output tsq_out_t out_req_o
);

  tsq_job_t push_job, pop_job;
  tsq_set_t set;
  logic     push, full, pop, empty, set_push, set_full;

  tsq_front u_front (
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .req_i   (in_req_i),
    .full_i  (full),
    .push_o  (push),
    .job_o   (push_job)
  );

  tsq_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .job_o   (pop_job)
  );

  tsq_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (empty),
    .q_job_i    (pop_job),
    .q_pop_o    (pop),
    .set_full_i (set_full),
    .set_push_o (set_push),
    .set_o      (set)
  );

  tsq_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (set_push),
    .set_i       (set),
    .full_o      (set_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule

// ----- rtl/tsq_front.sv -----
// front end: accepts segments and classifies them into queue entries
module tsq_front import tsq_pkg::*; (
  input  logic     valid_i,
  output logic     stall_o,
  input  tsq_in_t  req_i,
  input  logic     full_i,
  output logic     push_o,
  output tsq_job_t job_o
);

  logic [2:0][31:0] s, e, y;
  logic [2:0][32:0] diff;
  logic [2:0][32:0] dmag;

  assign stall_o = full_i;
  assign push_o  = valid_i & ~full_i;

  always_comb begin
    s = {req_i.start_z, req_i.start_y, req_i.start_x};
    e = {req_i.end_z, req_i.end_y, req_i.end_x};
    y = {req_i.eye_z, req_i.eye_y, req_i.eye_x};
    job_o = '0;
    for (int i = 0; i < 3; i++) begin
      diff[i] = {e[i][31], e[i]} - {s[i][31], s[i]};
      dmag[i] = diff[i][32] ? 33'(-diff[i]) : diff[i];
      job_o.pos_s[i]  = s[i];
      job_o.pos_e[i]  = e[i];
      job_o.ab_mag[i] = dmag[i][31:0];
      job_o.ab_neg[i] = diff[i][32];
      // twice the vector from the segment midpoint to the eye
      job_o.w2[i] = {y[i][31], y[i], 1'b0} - {{2{s[i][31]}}, s[i]}
                    - {{2{e[i][31]}}, e[i]};
    end
    job_o.hw    = req_i.radius;
    job_o.color = req_i.color_rgba;
    job_o.degen = ~|{dmag[2], dmag[1], dmag[0]};
  end

endmodule

// ----- rtl/tsq_queue.sv -----
// short queue between the front and back ends
module tsq_queue import tsq_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  tsq_job_t job_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output tsq_job_t job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  tsq_job_t        mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |=> !(cnt_q == '0) && (cnt_q <= CntW'(Depth)))
    else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");
`endif

endmodule

// ----- rtl/tsq_back.sv -----
// back end: length, direction, side vector and quad corners by a shared sequencer
module tsq_back import tsq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_empty_i,
  input  tsq_job_t q_job_i,
  output logic     q_pop_o,
  input  logic     set_full_i,
  output logic     set_push_o,
  output tsq_set_t set_o
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StLsum  = 4'd1;
  localparam logic [3:0] StLroot = 4'd2;
  localparam logic [3:0] StDdiv  = 4'd3;
  localparam logic [3:0] StRaw   = 4'd4;
  localparam logic [3:0] StSsum  = 4'd5;
  localparam logic [3:0] StSroot = 4'd6;
  localparam logic [3:0] StUdiv  = 4'd7;
  localparam logic [3:0] StScale = 4'd8;
  localparam logic [3:0] StOut   = 4'd9;

  localparam logic [6:0] LenRootSteps  = 7'd33;
  localparam logic [6:0] SideRootSteps = 7'd63;
  localparam logic [6:0] DirSteps      = 7'd29;
  localparam logic [6:0] UnitSteps     = 7'd31;
  localparam logic [6:0] LsumEnd       = 7'd5;
  localparam logic [6:0] RawEnd        = 7'd11;
  localparam logic [6:0] SsumEnd       = 7'd17;
  localparam logic [6:0] ScaleEnd      = 7'd11;

  logic [3:0]  state_q, state_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [1:0]  ax_q, ax_d, ax_nx;

  tsq_job_t         job_q, job_d;
  logic [127:0]     acc_q, acc_d, acc_nx;
  logic [125:0]     rad_q, rad_d;
  logic [63:0]      rem_q, rem_d, rem_nx;
  logic [62:0]      root_q, root_d, root_nx;
  logic [32:0]      len_q, len_d;
  logic [2:0][28:0] dir_q, dir_d;
  logic [2:0][63:0] raw_q, raw_d;
  logic [2:0][30:0] unit_q, unit_d;
  logic [2:0][31:0] side_q, side_d;
  logic [2:0][31:0] ext_q, ext_d;
  logic [63:0]      dvr_q, dvr_d, dvr_nx;
  logic [30:0]      quo_q, quo_d, quo_nx;
  logic             first_q, first_d;
  logic [67:0]      mul_q;

  logic [3:0]       idx;
  logic [1:0]       sel_a, sel_b, sel_j;
  logic [33:0]      ma, mb;
  logic [6:0]       sh;
  logic [2:0][33:0] w2_mag;
  logic [2:0]       w2_neg;
  logic [2:0][62:0] raw_mag;
  logic [65:0]      rt_sh, rt_trial;
  logic             rt_ge;
  logic [63:0]      dv_sh, dv_div;
  logic             dv_ge;
  logic [63:0]      raw_term;
  logic             raw_neg;
  logic [31:0]      scl_side, scl_ext;

  assign idx   = cnt_q[4:1];
  assign ax_nx = ax_q + 2'd1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w2_neg[i]  = job_q.w2[i][33];
      w2_mag[i]  = w2_neg[i] ? 34'(-job_q.w2[i]) : job_q.w2[i];
      raw_mag[i] = raw_q[i][63] ? 63'(-raw_q[i]) : raw_q[i][62:0];
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    sel_a = 2'd0;
    sel_b = 2'd0;
    sel_j = 2'd0;
    ma    = '0;
    mb    = '0;
    unique case (state_q)
      StLsum: begin
        sel_a = idx[1:0];
        ma    = {2'b0, job_q.ab_mag[sel_a]};
        mb    = {2'b0, job_q.ab_mag[sel_a]};
      end
      StRaw: begin
        unique case (idx)
          4'd0:    begin sel_a = 2'd1; sel_b = 2'd2; end
          4'd1:    begin sel_a = 2'd2; sel_b = 2'd1; end
          4'd2:    begin sel_a = 2'd2; sel_b = 2'd0; end
          4'd3:    begin sel_a = 2'd0; sel_b = 2'd2; end
          4'd4:    begin sel_a = 2'd0; sel_b = 2'd1; end
          default: begin sel_a = 2'd1; sel_b = 2'd0; end
        endcase
        ma = {5'b0, dir_q[sel_a]};
        mb = w2_mag[sel_b];
      end
      StSsum: begin
        if (idx < 4'd3) begin
          sel_a = 2'd0;
          sel_j = idx[1:0];
        end else if (idx < 4'd6) begin
          sel_a = 2'd1;
          sel_j = 2'(idx - 4'd3);
        end else begin
          sel_a = 2'd2;
          sel_j = 2'(idx - 4'd6);
        end
        unique case (sel_j)
          2'd0: begin
            ma = {2'b0, raw_mag[sel_a][31:0]};
            mb = {2'b0, raw_mag[sel_a][31:0]};
          end
          2'd1: begin
            ma = {3'b0, raw_mag[sel_a][62:32]};
            mb = {2'b0, raw_mag[sel_a][31:0]};
          end
          default: begin
            ma = {3'b0, raw_mag[sel_a][62:32]};
            mb = {3'b0, raw_mag[sel_a][62:32]};
          end
        endcase
      end
      StScale: begin
        if (idx < 4'd3) begin
          sel_a = idx[1:0];
          ma    = {3'b0, unit_q[sel_a]};
        end else begin
          sel_a = 2'(idx - 4'd3);
          ma    = {5'b0, dir_q[sel_a]};
        end
        mb = {3'b0, job_q.hw};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_q <= ma * mb;
  end

  // accumulate a registered product
  always_comb begin
    unique case (sel_j)
      2'd1:    sh = 7'd33;
      2'd2:    sh = 7'd64;
      default: sh = 7'd0;
    endcase
    acc_nx = acc_q + ({60'b0, mul_q} << sh);
  end

  // one root digit per cycle
  always_comb begin
    rt_sh    = {rem_q, rad_q[125:124]};
    rt_trial = {1'b0, root_q, 2'b01};
    rt_ge    = (rt_sh >= rt_trial);
    rem_nx   = rt_ge ? 64'(rt_sh - rt_trial) : rt_sh[63:0];
    root_nx  = {root_q[61:0], rt_ge};
  end

  // one quotient bit per cycle
  always_comb begin
    dv_div = (state_q == StDdiv) ? {31'b0, len_q} : {1'b0, root_q};
    dv_sh  = first_q ? dvr_q : {dvr_q[62:0], 1'b0};
    dv_ge  = (dv_sh >= dv_div);
    dvr_nx = dv_ge ? (dv_sh - dv_div) : dv_sh;
    quo_nx = {quo_q[29:0], dv_ge};
  end

  always_comb begin
    raw_neg  = job_q.ab_neg[sel_a] ^ w2_neg[sel_b] ^ idx[0];
    raw_term = {2'b0, mul_q[61:0]};
    scl_side = {1'b0, mul_q[60:30]};
    scl_ext  = {1'b0, mul_q[58:28]};
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ax_d    = ax_q;
    job_d   = job_q;
    acc_d   = acc_q;
    rad_d   = rad_q;
    rem_d   = rem_q;
    root_d  = root_q;
    len_d   = len_q;
    dir_d   = dir_q;
    raw_d   = raw_q;
    unit_d  = unit_q;
    side_d  = side_q;
    ext_d   = ext_q;
    dvr_d   = dvr_q;
    quo_d   = quo_q;
    first_d = first_q;
    q_pop_o    = 1'b0;
    set_push_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          job_d   = q_job_i;
          if (!q_job_i.degen) begin
            state_d = StLsum;
            cnt_d   = '0;
            acc_d   = '0;
          end
        end
      end
      StLsum: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q[0]) begin
          acc_d = acc_nx;
        end
        if (cnt_q == LsumEnd) begin
          state_d = StLroot;
          rad_d   = {acc_nx[65:0], 60'b0};
          rem_d   = '0;
          root_d  = '0;
          cnt_d   = LenRootSteps;
        end
      end
      StLroot: begin
        rem_d  = rem_nx;
        root_d = root_nx;
        rad_d  = {rad_q[123:0], 2'b00};
        cnt_d  = cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          len_d   = root_nx[32:0];
          state_d = StDdiv;
          ax_d    = 2'd0;
          dvr_d   = {32'b0, job_q.ab_mag[0]};
          quo_d   = '0;
          first_d = 1'b1;
          cnt_d   = DirSteps;
        end
      end
      StDdiv: begin
        dvr_d   = dvr_nx;
        quo_d   = quo_nx;
        first_d = 1'b0;
        cnt_d   = cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          dir_d[ax_q] = quo_nx[28:0];
          if (ax_q == 2'd2) begin
            state_d = StRaw;
            cnt_d   = '0;
            raw_d   = '0;
          end else begin
            ax_d    = ax_nx;
            dvr_d   = {32'b0, job_q.ab_mag[ax_nx]};
            quo_d   = '0;
            first_d = 1'b1;
            cnt_d   = DirSteps;
          end
        end
      end
      StRaw: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q[0]) begin
          raw_d[idx[2:1]] = raw_q[idx[2:1]] + (raw_neg ? 64'(-raw_term) : raw_term);
        end
        if (cnt_q == RawEnd) begin
          state_d = StSsum;
          cnt_d   = '0;
          acc_d   = '0;
        end
      end
      StSsum: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q[0]) begin
          acc_d = acc_nx;
        end
        if (cnt_q == SsumEnd) begin
          state_d = StSroot;
          rad_d   = acc_nx[125:0];
          rem_d   = '0;
          root_d  = '0;
          cnt_d   = SideRootSteps;
        end
      end
      StSroot: begin
        rem_d  = rem_nx;
        root_d = root_nx;
        rad_d  = {rad_q[123:0], 2'b00};
        cnt_d  = cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          if (root_nx < SideEps) begin
            state_d = StIdle;
          end else begin
            state_d = StUdiv;
            ax_d    = 2'd0;
            dvr_d   = {1'b0, raw_mag[0]};
            quo_d   = '0;
            first_d = 1'b1;
            cnt_d   = UnitSteps;
          end
        end
      end
      StUdiv: begin
        dvr_d   = dvr_nx;
        quo_d   = quo_nx;
        first_d = 1'b0;
        cnt_d   = cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          unit_d[ax_q] = quo_nx;
          if (ax_q == 2'd2) begin
            state_d = StScale;
            cnt_d   = '0;
          end else begin
            ax_d    = ax_nx;
            dvr_d   = {1'b0, raw_mag[ax_nx]};
            quo_d   = '0;
            first_d = 1'b1;
            cnt_d   = UnitSteps;
          end
        end
      end
      StScale: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q[0]) begin
          if (idx < 4'd3) begin
            side_d[sel_a] = raw_q[sel_a][63] ? 32'(-scl_side) : scl_side;
          end else begin
            ext_d[sel_a] = job_q.ab_neg[sel_a] ? 32'(-scl_ext) : scl_ext;
          end
        end
        if (cnt_q == ScaleEnd) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (!set_full_i) begin
          set_push_o = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      set_o.va[i] = {{2{job_q.pos_s[i][31]}}, job_q.pos_s[i]}
                    - {{2{ext_q[i][31]}}, ext_q[i]};
      set_o.vb[i] = {{2{job_q.pos_e[i][31]}}, job_q.pos_e[i]}
                    + {{2{ext_q[i][31]}}, ext_q[i]};
      set_o.side[i] = side_q[i];
    end
    set_o.color = job_q.color;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      ax_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ax_q    <= ax_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q   <= job_d;
    acc_q   <= acc_d;
    rad_q   <= rad_d;
    rem_q   <= rem_d;
    root_q  <= root_d;
    len_q   <= len_d;
    dir_q   <= dir_d;
    raw_q   <= raw_d;
    unit_q  <= unit_d;
    side_q  <= side_d;
    ext_q   <= ext_d;
    dvr_q   <= dvr_d;
    quo_q   <= quo_d;
    first_q <= first_d;
  end

`ifndef SYNTH
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    set_push_o |-> !set_full_i)
    else $error("corner set pushed into busy emitter");
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDdiv) |-> (len_q != '0))
    else $error("direction divide by zero length");
  a_side_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StUdiv) |-> (root_q >= SideEps))
    else $error("side divide below threshold");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (state_q == StIdle) || (state_q == StLsum))
    else $error("pop outside idle");
`endif

endmodule

// ----- rtl/tsq_emit.sv -----
// vertex emitter: walks the six quad vertices with saturation
module tsq_emit import tsq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  tsq_set_t set_i,
  output logic     full_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output tsq_out_t out_req_o
);

  localparam logic [2:0] LastVert = 3'(NumVerts - 1);
  // corner b on vertices one, two, four; plus side on two, four, five
  localparam logic [5:0] UseBMask = 6'b010110;
  localparam logic [5:0] PlusMask = 6'b110100;
  localparam logic signed [34:0] VMax = 35'sd2147483647;
  localparam logic signed [34:0] VMin = -35'sd2147483648;

  tsq_set_t   set_q;
  logic       full_q;
  logic [2:0] k_q;
  logic       take;
  logic [2:0][33:0]        base;
  logic signed [2:0][34:0] v;
  logic [2:0][31:0]        vs;

  assign full_o      = full_q;
  assign out_valid_o = full_q;
  assign take        = full_q & ~out_stall_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      base[i] = UseBMask[k_q] ? set_q.vb[i] : set_q.va[i];
      if (PlusMask[k_q]) begin
        v[i] = $signed({base[i][33], base[i]})
               + $signed({{3{set_q.side[i][31]}}, set_q.side[i]});
      end else begin
        v[i] = $signed({base[i][33], base[i]})
               - $signed({{3{set_q.side[i][31]}}, set_q.side[i]});
      end
      if ($signed(v[i]) > VMax) begin
        vs[i] = 32'h7fffffff;
      end else if ($signed(v[i]) < VMin) begin
        vs[i] = 32'h80000000;
      end else begin
        vs[i] = v[i][31:0];
      end
    end
    out_req_o.vertex_x     = vs[0];
    out_req_o.vertex_y     = vs[1];
    out_req_o.vertex_z     = vs[2];
    out_req_o.vertex_color = set_q.color;
    out_req_o.vertex_last  = (k_q == LastVert);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      set_q <= set_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      k_q    <= '0;
    end else begin
      if (push_i) begin
        full_q <= 1'b1;
        k_q    <= '0;
      end else if (take) begin
        if (k_q == LastVert) begin
          full_q <= 1'b0;
          k_q    <= '0;
        end else begin
          k_q <= k_q + 3'd1;
        end
      end
    end
  end

`ifndef SYNTH
  a_push_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_q)
    else $error("emitter overwritten while busy");
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= LastVert)
    else $error("vertex index out of range");
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && out_req_o.vertex_last && !push_i) |=> !full_q)
    else $error("emitter busy after last vertex");
`endif

endmodule

// ----- tb/sv/tb_thick_segment_quad_expand.sv -----
// self-checking testbench for the thick segment quad expander
module tb_thick_segment_quad_expand;
  import tsq_pkg::*;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid;
  logic     in_stall;
  tsq_in_t  in_req;
  logic     out_valid;
  logic     out_stall;
  tsq_out_t out_req;

  thick_segment_quad_expand dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_req_o  (out_req)
  );

  tsq_in_t  segment_q[$];
  tsq_out_t quad_vertex_q[$];
  int n_err;
  int n_sent;
  int n_vert;
  int n_culled;
  int burst_left;
  int gap_left;
  bit draining;
  int hold_left;
  bit hold_done;
  int phase_cnt;
  int stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #3200000;
    $display("tb_thick_segment_quad_expand NOT OK");
    $finish;
  end

  function automatic logic [63:0] isqrt128(logic [127:0] n);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if ({64'd0, t} * {64'd0, t} <= n) r = t;
    end
    return r;
  endfunction

  function automatic logic [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  task automatic predict_quad(tsq_in_t q);
    longint s[3], e[3], ab[3], dir[3], side[3], ext[3], va[3], vb[3];
    logic signed [127:0] dw[3], ww[3], raw[3];
    logic [127:0] acc, rm;
    logic [63:0] len, slen, unit, mg, hw;
    tsq_out_t v;
    bit use_b, plus;
    s[0] = q.start_x; s[1] = q.start_y; s[2] = q.start_z;
    e[0] = q.end_x;   e[1] = q.end_y;   e[2] = q.end_z;
    ww[0] = 128'(2 * longint'(q.eye_x) - s[0] - e[0]);
    ww[1] = 128'(2 * longint'(q.eye_y) - s[1] - e[1]);
    ww[2] = 128'(2 * longint'(q.eye_z) - s[2] - e[2]);
    hw = {33'd0, q.radius};
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      ab[i] = e[i] - s[i];
      mg = ab[i] < 0 ? -ab[i] : ab[i];
      acc += {64'd0, mg} * {64'd0, mg};
    end
    len = isqrt128(acc);
    if (len < 64'd1) begin
      n_culled++;
      return;
    end
    for (int i = 0; i < 3; i++) begin
      mg = ab[i] < 0 ? -ab[i] : ab[i];
      mg = (mg << 28) / len;
      dir[i] = ab[i] < 0 ? -longint'(mg) : longint'(mg);
      dw[i] = 128'(dir[i]);
    end
    raw[0] = dw[1] * ww[2] - dw[2] * ww[1];
    raw[1] = dw[2] * ww[0] - dw[0] * ww[2];
    raw[2] = dw[0] * ww[1] - dw[1] * ww[0];
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      rm = raw[i] < 0 ? -raw[i] : raw[i];
      acc += rm * rm;
    end
    slen = isqrt128(acc);
    if ({1'b0, slen} < {2'b0, SideEps}) begin
      n_culled++;
      return;
    end
    for (int i = 0; i < 3; i++) begin
      rm = raw[i] < 0 ? -raw[i] : raw[i];
      rm = (rm << 30) / {64'd0, slen};
      unit = rm[63:0];
      mg = (unit * hw) >> 30;
      side[i] = raw[i] < 0 ? -longint'(mg) : longint'(mg);
      mg = dir[i] < 0 ? -dir[i] : dir[i];
      mg = (mg * hw) >> 28;
      ext[i] = dir[i] < 0 ? -longint'(mg) : longint'(mg);
      va[i] = s[i] - ext[i];
      vb[i] = e[i] + ext[i];
    end
    for (int k = 0; k < 6; k++) begin
      use_b = (k == 1 || k == 2 || k == 4);
      plus = (k == 2 || k == 4 || k == 5);
      v.vertex_x = sat32((use_b ? vb[0] : va[0]) + (plus ? side[0] : -side[0]));
      v.vertex_y = sat32((use_b ? vb[1] : va[1]) + (plus ? side[1] : -side[1]));
      v.vertex_z = sat32((use_b ? vb[2] : va[2]) + (plus ? side[2] : -side[2]));
      v.vertex_color = q.color_rgba;
      v.vertex_last = (k == 5);
      quad_vertex_q.insert(quad_vertex_q.size(), v);
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h (vertex %0d)", what, got, want, n_vert);
    n_err++;
  endtask

  function automatic logic [31:0] rand_mag(int bits, bit neg_ok);
    logic [31:0] v;
    v = $urandom() & ((bits >= 32) ? 32'hffffffff : ((32'd1 << bits) - 1));
    if (neg_ok && $urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  function automatic tsq_in_t seg(longint sx, longint sy, longint sz, longint ex, longint ey,
                                  longint ez, longint px, longint py, longint pz,
                                  logic [30:0] hw, logic [31:0] col);
    tsq_in_t t;
    t.start_x = 32'(sx); t.start_y = 32'(sy); t.start_z = 32'(sz);
    t.end_x = 32'(ex);   t.end_y = 32'(ey);   t.end_z = 32'(ez);
    t.eye_x = 32'(px);   t.eye_y = 32'(py);   t.eye_z = 32'(pz);
    t.radius = hw;
    t.color_rgba = col;
    return t;
  endfunction

  task automatic add_seg(tsq_in_t t);
    segment_q.insert(segment_q.size(), t);
  endtask

  task automatic build_segments();
    tsq_in_t t;
    int scale, kind;
    longint one, mx, mn;
    one = 65536;
    mx = 64'sd2147483647;
    mn = -64'sd2147483648;
    // basic quad, zero length, edge-on, zero width
    add_seg(seg(0, 0, 0, one, 0, 0, 0, one, 0, 31'h8000, 32'h11223344));
    add_seg(seg(one, 2 * one, 3 * one, one, 2 * one, 3 * one, 0, 0, 0,
                31'h10000, 32'hffffffff));
    add_seg(seg(0, 0, 0, one, 0, 0, 5 * one, 0, 0, 31'h10000, 32'h0));
    add_seg(seg(0, 0, 0, one, 0, 0, one / 2, 0, 0, 31'h10000, 32'h0));
    add_seg(seg(0, 0, 0, 0, 0, one, one, one, 0, 31'h0, 32'h80808080));
    add_seg(seg(-one, -one, -one, one, one, one, 0, 0, 0, 31'h10000, 32'h1));
    // extremes and saturation
    add_seg(seg(mn, mn, mn, mx, mx, mx, mx, mn, 0, 31'h7fffffff, 32'hdeadbeef));
    add_seg(seg(mx, mx, mx, mn, mn, mn, mn, mx, mx, 31'h7fffffff, 32'h00ff00ff));
    add_seg(seg(mx, 0, 0, mx, one, 0, mx, 0, one, 31'h7fffffff, 32'h7f7f7f7f));
    add_seg(seg(mn, 0, 0, mn, 0, -one, mn, one, 0, 31'h7fffffff, 32'hfe000001));
    add_seg(seg(mn, mn, mn, mn, mn, mn, mx, mx, mx, 31'h7fffffff, 32'haaaaaaaa));
    add_seg(seg(0, 0, 0, 1, 0, 0, 0, 1, 0, 31'h1, 32'h55555555));
    add_seg(seg(0, 0, 0, 1, 0, 0, 0, 0, 0, 31'h1, 32'h55555555));
    add_seg(seg(0, 0, 0, mx, mx, mx, mn, mn, mn, 31'h7fffffff, 32'h0));
    add_seg(seg(3 * one, 0, 0, 3 * one, 0, 7 * one, 3 * one, 0, 100 * one,
                31'h20000, 32'h12345678));
    for (int n = 0; n < 265; n++) begin
      kind = $urandom_range(0, 99);
      scale = $urandom_range(4, 30);
      t.start_x = rand_mag(scale, 1);
      t.start_y = rand_mag(scale, 1);
      t.start_z = rand_mag(scale, 1);
      t.end_x = t.start_x + rand_mag(scale, 1);
      t.end_y = t.start_y + rand_mag(scale, 1);
      t.end_z = t.start_z + rand_mag(scale, 1);
      t.eye_x = rand_mag(scale + 1, 1);
      t.eye_y = rand_mag(scale + 1, 1);
      t.eye_z = rand_mag(scale + 1, 1);
      t.radius = 31'(rand_mag($urandom_range(1, 31), 0));
      t.color_rgba = $urandom();
      if (kind < 10) begin
        t = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
             $urandom(), $urandom(), $urandom(), 31'($urandom()), $urandom()};
      end else if (kind < 18) begin
        t.end_x = t.start_x; t.end_y = t.start_y; t.end_z = t.start_z;
      end else if (kind < 26) begin
        if ($urandom_range(0, 1)) begin
          t.eye_x = t.start_x; t.eye_y = t.start_y; t.eye_z = t.start_z;
        end else begin
          t.eye_x = t.end_x; t.eye_y = t.end_y; t.eye_z = t.end_z;
        end
      end
      add_seg(t);
    end
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_req <= '0;
      burst_left = 1;
      gap_left = 0;
      draining = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_quad(in_req);
        n_sent++;
        if (n_sent == 150) draining = 1;
      end
      if (draining && quad_vertex_q.size() == 0) draining = 0;
      if (in_valid && in_stall) begin
      end else if (draining || gap_left > 0 || segment_q.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid <= 1'b0;
      end else begin
        in_req <= segment_q.pop_front();
        in_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 10);
          gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 500);
        end
      end
    end
  end

  // vertex monitor and receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    tsq_out_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      hold_left = 0;
      hold_done = 0;
      phase_cnt = 0;
      stall_pct = 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_vert++;
        if (quad_vertex_q.size() == 0) begin
          report_mismatch("unexpected vertex", out_req.vertex_x, 32'h0);
        end else begin
          want = quad_vertex_q.pop_front();
          if (out_req.vertex_x !== want.vertex_x)
            report_mismatch("vertex_x", out_req.vertex_x, want.vertex_x);
          if (out_req.vertex_y !== want.vertex_y)
            report_mismatch("vertex_y", out_req.vertex_y, want.vertex_y);
          if (out_req.vertex_z !== want.vertex_z)
            report_mismatch("vertex_z", out_req.vertex_z, want.vertex_z);
          if (out_req.vertex_color !== want.vertex_color)
            report_mismatch("vertex_color", out_req.vertex_color, want.vertex_color);
          if (out_req.vertex_last !== want.vertex_last)
            report_mismatch("vertex_last", 32'(out_req.vertex_last), 32'(want.vertex_last));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && n_sent >= 60) begin
        hold_done = 1;
        hold_left = 4000;
        out_stall <= 1'b1;
      end else begin
        phase_cnt++;
        if (phase_cnt >= 97) begin
          phase_cnt = 0;
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 15;
            2: stall_pct = 50;
            default: stall_pct = 90;
          endcase
        end
        out_stall <= $urandom_range(0, 99) < stall_pct;
      end
    end
  end

  initial begin
    n_err = 0;
    n_sent = 0;
    n_vert = 0;
    n_culled = 0;
    rst_ni = 1'b0;
    build_segments();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (segment_q.size() != 0 || in_valid) @(posedge clk_i);
    while (quad_vertex_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    $display("segments accepted: %0d, culled: %0d, vertices checked: %0d",
             n_sent, n_culled, n_vert);
    $display("covered bursts, random output stalls, one long hold-off and one drain pause");
    if (n_err == 0 && quad_vertex_q.size() == 0) begin
      $display("tb_thick_segment_quad_expand OK");
    end else begin
      $display("tb_thick_segment_quad_expand NOT OK");
    end
    $finish;
  end

endmodule
